>>> design/ppla_pkg.sv
// Shared types, register codes and arithmetic helpers for the pressure peak level accumulator.
package ppla_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEVEL_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_AVERAGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_AMOUNT   = 3'd4;

    localparam logic [15:0] RST_DECAY_FACTOR   = 16'd65000;
    localparam logic        RST_USE_AVERAGE    = 1'b1;
    localparam logic [5:0]  RST_WINDOW_LEN     = 6'd16;
    localparam logic [15:0] RST_PEAK_THRESHOLD = 16'd600;
    localparam logic [7:0]  RST_BOOST_AMOUNT   = 8'd0;

    // Division of a 16-bit value by ten as a multiply by ceil(2^19 / 10) and a shift.
    localparam logic [15:0] THR_RECIP = 16'd52429;
    localparam int          THR_SHIFT = 19;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_start;
        logic peak;
        logic boost;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
        logic [LEVEL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEVEL_W] ? LEVEL_MAX : s[LEVEL_W-1:0];
    endfunction

endpackage

>>> design/ppla_div.sv
// Restoring serial divider that produces one quotient bit per cycle.
module ppla_div #(
    parameter int DEND_W = 21,
    parameter int DSOR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEND_W-1:0] i_dividend,
    input  logic [DSOR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DEND_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DEND_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEND_W-1:0] r_quo;
    logic [DSOR_W-1:0] r_rem;
    logic [DSOR_W-1:0] r_dsor;
    logic [DSOR_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DEND_W-1]};
    assign fits  = trial >= {1'b0, r_dsor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DEND_W-2:0], fits};
            r_rem <= fits ? DSOR_W'(trial - {1'b0, r_dsor}) : trial[DSOR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> design/ppla_dp.sv
// Datapath: configuration registers, sample window, level arithmetic and output register.
module ppla_dp #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ppla_pkg::t_cmd                    i_cmd,
    output ppla_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [ppla_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ppla_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [15:0]                       i_pressure_sample,
    input  logic                              i_boost_active,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [15:0]                       o_level,
    output logic [15:0]                       o_average_pressure,
    output logic                              o_level_changed
);
    import ppla_pkg::*;

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

    logic [15:0] r_decay;
    logic        r_use_avg;
    logic [5:0]  r_win_len;
    logic [15:0] r_thr;
    logic [7:0]  r_boost_amt;
    logic [15:0] r_thr_tenth;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_boost;
    logic [PTR_W-1:0]       r_slot;
    logic [PTR_W-1:0]       r_ptr;
    logic [CNT_W-1:0]       r_fill;
    logic [SUM_W-1:0]       r_sum;
    logic [31:0]            r_prod;
    logic [15:0]            r_level;
    logic                   r_changed;
    logic [15:0]            r_prev;
    logic [15:0]            r_valley;

    logic        r_out_valid;
    logic [15:0] r_o_level;
    logic [15:0] r_o_avg;
    logic        r_o_chg;

    logic [CNT_W-1:0]       len;
    logic [PTR_W-1:0]       ptr_eff;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [CNT_W-1:0]       slot_inc;
    logic [PTR_W-1:0]       n_ptr;
    logic [15:0]            decayed;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quot;
    logic [15:0]            avg16;
    logic [15:0]            check;
    logic [15:0]            rise;
    logic [15:0]            n_level_pk;
    logic [15:0]            n_valley;
    logic [15:0]            n_level_bst;
    logic                   out_take;
    logic                   cfg_wl;

    always_comb begin
        if (r_win_len == 6'd0) begin
            len = CNT_W'(1);
        end else if (32'(r_win_len) > 32'(MAX_WINDOW)) begin
            len = CNT_W'(MAX_WINDOW);
        end else begin
            len = CNT_W'(r_win_len);
        end
    end

    assign ptr_eff  = (CNT_W'(r_ptr) >= len) ? '0 : r_ptr;
    assign old_val  = (CNT_W'(r_slot) < r_fill) ? r_rd : '0;
    assign slot_inc = CNT_W'(r_slot) + CNT_W'(1);
    assign n_ptr    = (slot_inc >= len) ? '0 : PTR_W'(slot_inc);
    assign decayed  = r_prod[31:16];
    assign avg16    = 16'(div_quot[SAMPLE_BITS-1:0]);
    assign check    = r_use_avg ? avg16 : 16'(r_sample);
    assign rise     = r_prev - r_valley;
    assign out_take = r_out_valid && !i_out_stall;
    assign cfg_wl   = i_cfg_we && (i_cfg_idx == REG_WINDOW_LEN);

    // A falling edge after a large enough rise adds the rise and restarts the valley.
    always_comb begin
        n_level_pk = r_level;
        n_valley   = r_valley;
        if (check < r_prev) begin
            if ((r_prev > r_valley) && (rise >= r_thr_tenth)) begin
                n_level_pk = sat_add(r_level, rise);
                n_valley   = check;
            end
            if (check < n_valley) begin
                n_valley = check;
            end
        end
    end

    assign n_level_bst = (r_boost && (r_boost_amt != 8'd0))
                         ? sat_add(r_level, 16'(r_boost_amt)) : r_level;

    ppla_div #(
        .DEND_W (SUM_W),
        .DSOR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (len),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= RST_DECAY_FACTOR;
            r_use_avg   <= RST_USE_AVERAGE;
            r_win_len   <= RST_WINDOW_LEN;
            r_thr       <= RST_PEAK_THRESHOLD;
            r_boost_amt <= RST_BOOST_AMOUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DECAY_FACTOR:   r_decay     <= i_cfg_data[15:0];
                REG_USE_AVERAGE:    r_use_avg   <= i_cfg_data[0];
                REG_WINDOW_LEN:     r_win_len   <= i_cfg_data[5:0];
                REG_PEAK_THRESHOLD: r_thr       <= i_cfg_data[15:0];
                REG_BOOST_AMOUNT:   r_boost_amt <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_tenth <= 16'((32'(r_thr) * 32'(THR_RECIP)) >> THR_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[ptr_eff];
        end
        if (i_cmd.update) begin
            r_mem[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_pressure_sample[SAMPLE_BITS-1:0];
            r_boost  <= i_boost_active;
            r_slot   <= ptr_eff;
            r_prod   <= 32'(r_level) * 32'(r_decay);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_ptr     <= '0;
            r_fill    <= '0;
            r_level   <= '0;
            r_changed <= 1'b0;
            r_prev    <= '0;
            r_valley  <= '0;
        end else begin
            if (cfg_wl) begin
                r_sum  <= '0;
                r_ptr  <= '0;
                r_fill <= '0;
            end else if (i_cmd.update) begin
                r_sum <= r_sum - SUM_W'(old_val) + SUM_W'(r_sample);
                r_ptr <= n_ptr;
                if (CNT_W'(r_slot) == r_fill) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.update) begin
                r_level   <= decayed;
                r_changed <= decayed != r_level;
            end
            if (i_cmd.peak) begin
                r_level  <= n_level_pk;
                r_valley <= n_valley;
                r_prev   <= check;
                if (n_level_pk != r_level) begin
                    r_changed <= 1'b1;
                end
            end
            if (i_cmd.boost) begin
                r_level <= n_level_bst;
                if (n_level_bst != r_level) begin
                    r_changed <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_level <= r_level;
            r_o_avg   <= avg16;
            r_o_chg   <= r_changed;
        end
    end

    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = !r_out_valid || out_take;
    assign o_out_valid        = r_out_valid;
    assign o_level            = r_o_level;
    assign o_average_pressure = r_o_avg;
    assign o_level_changed    = r_o_chg;

    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_ptr) < len)
        else $error("Window pointer is outside the active window.");

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= len)
        else $error("Window fill count exceeds the active window length.");

    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_out_valid)
        else $error("Result was pushed but the output register is empty.");

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || !i_out_stall))
        else $error("Result pushed over a beat that has not been taken.");

endmodule

>>> design/ppla_ctrl.sv
// Controller state machine that sequences the datapath through one sample.
module ppla_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ppla_pkg::t_sts i_sts,
    output ppla_pkg::t_cmd o_cmd
);
    import ppla_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_DIVS  = 3'd2;
    localparam logic [2:0] S_DIVW  = 3'd3;
    localparam logic [2:0] S_PEAK  = 3'd4;
    localparam logic [2:0] S_BOOST = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_UPD;
            S_UPD:   n_state = S_DIVS;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW:  if (i_sts.div_done) n_state = S_PEAK;
            S_PEAK:  n_state = S_BOOST;
            S_BOOST: n_state = S_PUSH;
            S_PUSH:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.update    = r_state == S_UPD;
    assign o_cmd.div_start = r_state == S_DIVS;
    assign o_cmd.peak      = r_state == S_PEAK;
    assign o_cmd.boost     = r_state == S_BOOST;
    assign o_cmd.push      = (r_state == S_PUSH) && i_sts.out_free;

endmodule

>>> design/pressure_peak_level_accumulator.sv
// Top level of the pressure peak level accumulator: controller plus datapath.
//
//  Channel  Direction  Handshake                 Beat contents
//  input    in         i_in_valid / o_in_stall   i_pressure_sample, i_boost_active
//  output   out        o_out_valid / i_out_stall o_level, o_average_pressure, o_level_changed
//  config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Each accepted sample passes in turn through the update, divider, peak, boost and push
// states; the serial divider that forms the window average works on a dividend of
// SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) bits. No new sample is accepted before push.
// Reset is synchronous and active low and restores the register defaults and an empty window.
// A new sample is accepted while the previous result still waits in the output register;
// a stalled output holds the block only when the next result is ready to be written.
module pressure_peak_level_accumulator #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [15:0]                     i_pressure_sample,
    input  logic                            i_boost_active,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [15:0]                     o_level,
    output logic [15:0]                     o_average_pressure,
    output logic                            o_level_changed
);
    import ppla_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ppla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppla_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_pressure_sample  (i_pressure_sample),
        .i_boost_active     (i_boost_active),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_level            (o_level),
        .o_average_pressure (o_average_pressure),
        .o_level_changed    (o_level_changed)
    );

endmodule
